### hdl/sct_pkg.sv
// shared constants, types and helper functions for the sine/cosine taylor unit
// no dependencies; used by sct_cell, sine_cosine_taylor_unit and the testbench
package sct_pkg;

   localparam int TERMS      = 25;
   localparam int NCELLS     = TERMS - 1;
   localparam int FRAC       = 48;
   localparam int PROD_LSB   = FRAC;
   localparam int PROD_BITS  = 62;
   localparam int OUT_SHIFT  = FRAC - 30;
   localparam int XMAG_W     = 56;

   localparam logic [63:0] TWO_PI_Q48 = 64'd1768559438007110;
   localparam logic [63:0] ONE_Q48    = 64'd1 << FRAC;

   // largest whole number of turns in a 32-bit angle
   localparam int KMAX = int'((64'd1 << (XMAG_W - 1)) / TWO_PI_Q48);
   localparam int KW   = $clog2(KMAX + 1);

   typedef struct packed {
      logic               valid;
      logic        [63:0] x2;
      logic signed [63:0] sin_term;
      logic signed [63:0] sin_sum;
      logic signed [63:0] cos_term;
      logic signed [63:0] cos_sum;
   } link_type;

   typedef struct packed {
      logic [63:0] recip;
      logic [6:0]  shift;
   } div_type;

   function automatic int unsigned sin_div(input int unsigned i);
      return (2 * i) * (2 * i + 1);
   endfunction

   function automatic int unsigned cos_div(input int unsigned i);
      return (2 * i - 1) * (2 * i);
   endfunction

   function automatic logic [XMAG_W-1:0] turn_multiple(input logic [KW-1:0] k);
      return XMAG_W'(k) * TWO_PI_Q48[XMAG_W-1:0];
   endfunction

endpackage

### hdl/sct_mul64.sv
// 64x64 unsigned multiplier, four 32x32 partial products then one summing stage
// both stages registered, advances on enable; uses nothing else
module sct_mul64 (
   input  logic         clock,
   input  logic         enable,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic [127:0] product
);

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] product_ff, product_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff <= a[31:0] * b[31:0];
         lh_ff <= a[31:0] * b[63:32];
         hl_ff <= a[63:32] * b[31:0];
         hh_ff <= a[63:32] * b[63:32];
         product_ff <= product_in;
      end
   end

   always_comb begin
      product_in = {hh_ff, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0};
   end

   assign product = product_ff;

endmodule

### hdl/sct_cell.sv
// one taylor step for both series: term times x*x, exact divide by a constant, sum update
// uses sct_pkg and sct_mul64; multiply, divide and sum update are all registered
module sct_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  sct_pkg::link_type link_in,
   input  sct_pkg::div_type  sin_div,
   input  sct_pkg::div_type  cos_div,
   output sct_pkg::link_type link_out
);

   typedef struct packed {
      logic        [63:0] x2;
      logic               sin_neg;
      logic               cos_neg;
      logic signed [63:0] sin_sum;
      logic signed [63:0] cos_sum;
   } side_type;

   side_type          side_ff [4];
   logic [3:0]        valid_ff;
   sct_pkg::link_type link_ff, link_in_next;

   logic [63:0]  sin_mag, cos_mag;
   logic [127:0] sin_prod, cos_prod, sin_qprod, cos_qprod;
   logic [127:0] sin_shifted, cos_shifted;
   logic [63:0]  sin_q, cos_q;
   logic signed [63:0] sin_new, cos_new;

   assign sin_mag = link_in.sin_term[63] ? 64'(-link_in.sin_term) : 64'(link_in.sin_term);
   assign cos_mag = link_in.cos_term[63] ? 64'(-link_in.cos_term) : 64'(link_in.cos_term);

   sct_mul64 u_sin_term (.clock, .enable, .a(sin_mag), .b(link_in.x2), .product(sin_prod));
   sct_mul64 u_cos_term (.clock, .enable, .a(cos_mag), .b(link_in.x2), .product(cos_prod));

   sct_mul64 u_sin_div (
      .clock, .enable,
      .a({2'b00, sin_prod[sct_pkg::PROD_LSB +: sct_pkg::PROD_BITS]}),
      .b(sin_div.recip), .product(sin_qprod)
   );
   sct_mul64 u_cos_div (
      .clock, .enable,
      .a({2'b00, cos_prod[sct_pkg::PROD_LSB +: sct_pkg::PROD_BITS]}),
      .b(cos_div.recip), .product(cos_qprod)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= '{x2: link_in.x2, sin_neg: link_in.sin_term[63],
                         cos_neg: link_in.cos_term[63], sin_sum: link_in.sin_sum,
                         cos_sum: link_in.cos_sum};
         for (int s = 1; s < 4; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         link_ff.valid <= 1'b0;
      end else if (enable) begin
         valid_ff      <= {valid_ff[2:0], link_in.valid};
         link_ff.valid <= link_in_next.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         link_ff.x2       <= link_in_next.x2;
         link_ff.sin_term <= link_in_next.sin_term;
         link_ff.sin_sum  <= link_in_next.sin_sum;
         link_ff.cos_term <= link_in_next.cos_term;
         link_ff.cos_sum  <= link_in_next.cos_sum;
      end
   end

   always_comb begin
      sin_shifted = sin_qprod >> sin_div.shift;
      cos_shifted = cos_qprod >> cos_div.shift;
      sin_q = {2'b00, sin_shifted[sct_pkg::PROD_BITS-1:0]};
      cos_q = {2'b00, cos_shifted[sct_pkg::PROD_BITS-1:0]};
      // next term takes the opposite sign of the old one
      sin_new = side_ff[3].sin_neg ? signed'(sin_q) : -signed'(sin_q);
      cos_new = side_ff[3].cos_neg ? signed'(cos_q) : -signed'(cos_q);
      link_in_next.valid    = valid_ff[3];
      link_in_next.x2       = side_ff[3].x2;
      link_in_next.sin_term = sin_new;
      link_in_next.sin_sum  = side_ff[3].sin_sum + sin_new;
      link_in_next.cos_term = cos_new;
      link_in_next.cos_sum  = side_ff[3].cos_sum + cos_new;
   end

   assign link_out = link_ff;

endmodule

### hdl/sine_cosine_taylor_unit.sv
// top level: angle reduction, x*x, chain of taylor cells, output scaling and saturation
// uses sct_pkg, sct_mul64 and sct_cell
//
//   port group | direction | payload
//   req_       | in        | angle  Q8.24 signed
//   rsp_       | out       | sine, cosine  Q2.30 signed, saturated
//
// one request per cycle while no held result stalls the output
// each cell holds two multiplier pairs, both registered, plus an update stage
// reset clears valid bits only; the pipeline is empty afterwards
// rsp_stall on a held result freezes every stage and raises req_stall in the same cycle
module sine_cosine_taylor_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sine,
   output logic signed [31:0] rsp_cosine
);

   localparam int KW = sct_pkg::KW;
   localparam int XW = sct_pkg::XMAG_W;

   logic enable;

   logic                  va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic [sct_pkg::KMAX-1:0] therm_ff, therm_in;
   logic [31:0]           mag_a_ff, mag_b_ff, mag_in;
   logic                  neg_a_ff, neg_b_ff, neg_c_ff;
   logic [KW-1:0]         k_ff;
   logic [XW-1:0]         xmag_a, rem_in;
   logic [63:0]           rem_ff;
   logic signed [63:0]    x_d_ff, x_e_ff, x_c;
   logic [127:0]          x2_prod;

   sct_pkg::link_type link [sct_pkg::NCELLS+1];
   sct_pkg::link_type head_ff;

   logic signed [63:0] sin_round, cos_round;
   logic signed [45:0] sin_scaled, cos_scaled;
   logic signed [31:0] sine_ff, cosine_ff, sine_in, cosine_in;
   logic               rsp_valid_ff;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // angle magnitude, whole-turn thermometer, remainder and signed reduced angle
   always_comb begin
      mag_in = req_angle[31] ? 32'(-req_angle) : 32'(req_angle);
      xmag_a = {mag_in, 24'd0};
      for (int j = 0; j < sct_pkg::KMAX; j++) begin
         therm_in[j] = xmag_a >= sct_pkg::turn_multiple(KW'(j + 1));
      end
      rem_in = {mag_b_ff, 24'd0} - sct_pkg::turn_multiple(k_ff);
      x_c    = neg_c_ff ? -signed'(rem_ff) : signed'(rem_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         head_ff.valid <= 1'b0;
      end else if (enable) begin
         va_ff <= req_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         head_ff.valid <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         therm_ff <= therm_in;
         mag_a_ff <= mag_in;
         neg_a_ff <= req_angle[31];
         k_ff     <= KW'($countones(therm_ff));
         mag_b_ff <= mag_a_ff;
         neg_b_ff <= neg_a_ff;
         rem_ff   <= 64'(rem_in);
         neg_c_ff <= neg_b_ff;
         x_d_ff   <= x_c;
         x_e_ff   <= x_d_ff;
         head_ff.x2       <= {2'b00, x2_prod[sct_pkg::PROD_LSB +: sct_pkg::PROD_BITS]};
         head_ff.sin_term <= x_e_ff;
         head_ff.sin_sum  <= x_e_ff;
         head_ff.cos_term <= signed'(sct_pkg::ONE_Q48);
         head_ff.cos_sum  <= signed'(sct_pkg::ONE_Q48);
      end
   end

   sct_mul64 u_square (.clock, .enable, .a(rem_ff), .b(rem_ff), .product(x2_prod));

   assign link[0] = head_ff;

   for (genvar c = 0; c < sct_pkg::NCELLS; c++) begin : g_cell
      localparam int unsigned SD = sct_pkg::sin_div(c + 1);
      localparam int unsigned CD = sct_pkg::cos_div(c + 1);
      localparam int SL = $clog2(SD);
      localparam int CL = $clog2(CD);
      localparam logic [127:0] SM =
         ((128'd1 << (sct_pkg::PROD_BITS + SL)) + 128'(SD) - 128'd1) / 128'(SD);
      localparam logic [127:0] CM =
         ((128'd1 << (sct_pkg::PROD_BITS + CL)) + 128'(CD) - 128'd1) / 128'(CD);

      sct_pkg::div_type sin_div, cos_div;
      assign sin_div = '{recip: SM[63:0], shift: 7'(sct_pkg::PROD_BITS + SL)};
      assign cos_div = '{recip: CM[63:0], shift: 7'(sct_pkg::PROD_BITS + CL)};

      sct_cell u_cell (
         .clock, .reset, .enable,
         .link_in(link[c]), .sin_div(sin_div), .cos_div(cos_div),
         .link_out(link[c+1])
      );
   end

   // scale to Q2.30 truncating toward zero, then saturate
   always_comb begin
      sin_round  = link[sct_pkg::NCELLS].sin_sum
                 + (link[sct_pkg::NCELLS].sin_sum[63] ? 64'sd262143 : 64'sd0);
      cos_round  = link[sct_pkg::NCELLS].cos_sum
                 + (link[sct_pkg::NCELLS].cos_sum[63] ? 64'sd262143 : 64'sd0);
      sin_scaled = 46'(sin_round >>> sct_pkg::OUT_SHIFT);
      cos_scaled = 46'(cos_round >>> sct_pkg::OUT_SHIFT);
      if (sin_scaled > 46'sd2147483647) begin
         sine_in = 32'sh7FFFFFFF;
      end else if (sin_scaled < -46'sd2147483648) begin
         sine_in = 32'sh80000000;
      end else begin
         sine_in = sin_scaled[31:0];
      end
      if (cos_scaled > 46'sd2147483647) begin
         cosine_in = 32'sh7FFFFFFF;
      end else if (cos_scaled < -46'sd2147483648) begin
         cosine_in = 32'sh80000000;
      end else begin
         cosine_in = cos_scaled[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= link[sct_pkg::NCELLS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sine   = sine_ff;
   assign rsp_cosine = cosine_ff;

endmodule

### hdl/sct_checker.sv
// port-level checks for sine_cosine_taylor_unit, attached by bind
// uses only the top level's ports
module sct_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [31:0] req_angle,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_sine,
   input logic signed [31:0] rsp_cosine
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sine) && $stable(rsp_cosine))
      else $error("result changed while stalled");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result held");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request refused with empty output");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sine_cosine_taylor_unit sct_checker u_checker (.*);

### dv/tb_top.sv
// testbench for sine_cosine_taylor_unit: directed and random angles checked against a
// bit-exact taylor-series predictor, with random gaps on the request and response sides
// depends on hdl/sct_pkg.sv and hdl/sine_cosine_taylor_unit.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int     LATENCY    = 5 * (sct_pkg::TERMS - 1) + 7;
   localparam int     CYCLE_MAX  = 900000;
   localparam longint TURN_Q48   = 64'sd1768559438007110;
   localparam longint UNIT_Q48   = 64'sd1 <<< sct_pkg::FRAC;
   localparam int     SPAN_Q824  = 105414357;

   typedef struct packed {
      logic signed [31:0] sine;
      logic signed [31:0] cosine;
   } trig_pair_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_sine;
   logic signed [31:0] rsp_cosine;

   trig_pair_type pending_pairs[$];
   int            error_count = 0;
   int            cycle_count = 0;
   bit            no_gaps = 1'b0;

   sine_cosine_taylor_unit uut (.*);

   always #5 clock = ~clock;

   function automatic longint mul_q48(input longint a, input longint b);
      logic [63:0]  ma, mb;
      logic [127:0] prod;
      logic [63:0]  mag;
      ma   = (a < 0) ? 64'(-a) : 64'(a);
      mb   = (b < 0) ? 64'(-b) : 64'(b);
      prod = {64'd0, ma} * {64'd0, mb};
      mag  = prod[111:48] & 64'h3FFF_FFFF_FFFF_FFFF;
      return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [31:0] to_q230(input longint v);
      longint s;
      s = v / (64'sd1 <<< (sct_pkg::FRAC - 30));
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   function automatic trig_pair_type taylor_sin_cos(input logic signed [31:0] angle);
      longint        x, k, x2, term, sin_sum, cos_sum;
      trig_pair_type r;
      x = longint'(angle) <<< (sct_pkg::FRAC - 24);
      k = x / TURN_Q48;
      x = x - k * TURN_Q48;
      if (x > TURN_Q48) x = x - TURN_Q48;
      if (x < -TURN_Q48) x = x + TURN_Q48;
      x2 = mul_q48(x, x);
      term = x;
      sin_sum = x;
      for (int i = 1; i < sct_pkg::TERMS; i++) begin
         term = -(mul_q48(term, x2) / (longint'(2 * i) * longint'(2 * i + 1)));
         sin_sum += term;
      end
      term = UNIT_Q48;
      cos_sum = UNIT_Q48;
      for (int i = 1; i < sct_pkg::TERMS; i++) begin
         term = -(mul_q48(term, x2) / (longint'(2 * i - 1) * longint'(2 * i)));
         cos_sum += term;
      end
      r.sine = to_q230(sin_sum);
      r.cosine = to_q230(cos_sum);
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (no_gaps || p < 60) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // one request: optional idle gap, then hold until accepted
   task automatic send_angle(input logic signed [31:0] angle);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         req_angle = $urandom;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_angle = angle;
      do @(posedge clock); while (req_stall);
      pending_pairs.push_back(taylor_sin_cos(angle));
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // response side stall
   always @(negedge clock) begin
      int p;
      p = $urandom_range(99);
      if (reset || no_gaps) rsp_stall = 1'b0;
      else if (p < 65) rsp_stall = 1'b0;
      else if (p < 98) rsp_stall = 1'b1;
      else begin
         rsp_stall = 1'b1;
         repeat ($urandom_range(40, 10)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      trig_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pairs.size() == 0) begin
            $display("%0t: unexpected response sine %h cosine %h", $time, rsp_sine,
                     rsp_cosine);
            error_count++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_sine !== want.sine) begin
               $display("%0t: sine expected %h actual %h", $time, want.sine, rsp_sine);
               error_count++;
            end
            if (rsp_cosine !== want.cosine) begin
               $display("%0t: cosine expected %h actual %h", $time, want.cosine,
                        rsp_cosine);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_MAX) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      logic signed [31:0] corner[] = '{32'sh0, 32'sh1, -32'sh1, 32'sh7FFF_FFFF,
         -32'sh8000_0000, 32'sh0324_3F6A, -32'sh0324_3F6A, 32'sh0648_7ED5,
         -32'sh0648_7ED5, 32'sh0648_7ED6, 32'sh0648_7ED4, 32'sh0192_1FB5,
         -32'sh0192_1FB5, 32'sh04B6_5F1F, 32'sh0100_0000, -32'sh0100_0000,
         32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7F00_0000, -32'sh7F00_0000,
         32'sh7A5F_1E92, 32'sh0000_FFFF, 32'shFFFF_0000};
      foreach (corner[i]) send_angle(corner[i]);
      drop_valid();
   endtask

   task automatic test_random(input int count);
      int p;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(99);
         if (p < 50) send_angle($urandom);
         else if (p < 90) send_angle($urandom_range(2 * SPAN_Q824, 0) - SPAN_Q824);
         else send_angle($urandom_range(255, 0) - 128);
      end
      drop_valid();
   endtask

   task automatic test_streaming(input int count);
      no_gaps = 1'b1;
      for (int i = 0; i < count; i++) send_angle($urandom);
      drop_valid();
      no_gaps = 1'b0;
   endtask

   task automatic test_drain();
      wait (pending_pairs.size() == 0);
      test_random(20);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(600);
      test_drain();
      test_streaming(300);
      test_random(600);
      wait (pending_pairs.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_pairs.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
hdl/sct_pkg.sv
hdl/sct_mul64.sv
hdl/sct_cell.sv
hdl/sine_cosine_taylor_unit.sv
hdl/sct_checker.sv
dv/tb_top.sv
